/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while arst_n is low
`define CLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never hold
`define CLCD_NEVER(lbl, expr, msg) \
	`CLCD_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/clcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

	localparam int FUNCTION_SET_REPEATS = 3;
	localparam int INIT_TAIL_CMDS = 5;
	localparam int INIT_WRITES = FUNCTION_SET_REPEATS + INIT_TAIL_CMDS;
	localparam int WR_W = $clog2(INIT_WRITES);
	localparam int TAIL_IDX_W = $clog2(INIT_TAIL_CMDS);

	typedef logic [1:0]  op_t;
	typedef logic [7:0]  byte_t;
	typedef logic [15:0] us_t;
	typedef logic [16:0] hold_t;
	typedef logic [2:0]  cfg_idx_t;

	localparam op_t OP_INIT = 2'd0;
	localparam op_t OP_CMD  = 2'd1;
	localparam op_t OP_CHAR = 2'd2;

	localparam cfg_idx_t REG_PULSE      = 3'd0;
	localparam cfg_idx_t REG_SETTLE     = 3'd1;
	localparam cfg_idx_t REG_POWER_WAIT = 3'd2;
	localparam cfg_idx_t REG_INIT_WAIT  = 3'd3;
	localparam cfg_idx_t REG_CLEAR_WAIT = 3'd4;

	localparam byte_t CMD_FUNC_SET_8  = 8'h30;
	localparam byte_t CMD_FUNC_SET_2L = 8'h38;
	localparam byte_t CMD_DISPLAY_ON  = 8'h0C;
	localparam byte_t CMD_ENTRY_MODE  = 8'h06;
	localparam byte_t CMD_CLEAR       = 8'h01;
	localparam byte_t CMD_HOME        = 8'h02;

	typedef struct packed {
		op_t   op;
		byte_t value;
		logic  clr;
	} req_t;

	typedef struct packed {
		byte_t lcd_data;
		logic  register_select;
		logic  enable;
		hold_t hold_us;
		logic  last;
	} phase_t;

	function automatic byte_t init_tail_cmd(input logic [TAIL_IDX_W-1:0] idx);
		byte_t c;
		unique case (idx)
			TAIL_IDX_W'(0): c = CMD_FUNC_SET_2L;
			TAIL_IDX_W'(1): c = CMD_DISPLAY_ON;
			TAIL_IDX_W'(2): c = CMD_ENTRY_MODE;
			TAIL_IDX_W'(3): c = CMD_CLEAR;
			TAIL_IDX_W'(4): c = CMD_HOME;
			default:        c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_clear_cmd(input byte_t b);
		return (b == CMD_CLEAR) || (b == CMD_HOME);
	endfunction

endpackage

`default_nettype wire

/* rtl/char_lcd_write_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Character LCD write sequencer, 8-bit interface. Push one request (operation 0 initialize,
// 1 command byte, 2 character byte; 3 is taken and dropped) and pop timed pin phases:
// data byte, register select, enable level, hold time in microseconds, and last on the
// final phase of the request. A command or character write yields two phases; initialize
// yields 11 + 2 * FUNCTION_SET_REPEATS phases (17). The back sequencer emits one phase per
// cycle whenever the two-entry result queue has room, and a two-entry request queue in front
// lets requests be pushed while a run is still going out. Timing registers are written
// through cfg_we/cfg_index/cfg_data (pulse, settle, power-on wait, init wait, clear wait)
// and should change only while idle.

module char_lcd_write_sequencer_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  clcd_pkg::op_t       operation,
	input  clcd_pkg::byte_t     value,
	output logic                empty,
	input  wire                 pop,
	output clcd_pkg::byte_t     lcd_data,
	output logic                register_select,
	output logic                enable,
	output clcd_pkg::hold_t     hold_us,
	output logic                last,
	input  wire                 cfg_we,
	input  clcd_pkg::cfg_idx_t  cfg_index,
	input  clcd_pkg::us_t       cfg_data
);
	import clcd_pkg::*;

	logic   req_valid;
	req_t   req_data;
	logic   req_pop;
	logic   out_full;
	logic   out_push;
	phase_t out_data;
	phase_t head;

	clcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.value     (value),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_pop   (req_pop)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_pop   (req_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	clcd_out_q u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (out_push),
		.in_full (out_full),
		.in_data (out_data),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	assign lcd_data = head.lcd_data;
	assign register_select = head.register_select;
	assign enable = head.enable;
	assign hold_us = head.hold_us;
	assign last = head.last;

endmodule

`default_nettype wire

/* rtl/clcd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clcd_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  clcd_pkg::op_t      operation,
	input  clcd_pkg::byte_t    value,
	output logic               req_valid,
	output clcd_pkg::req_t     req_data,
	input  wire                req_pop
);
	import clcd_pkg::*;

	req_t       mem [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       known_op;
	logic       wr_en;
	req_t       cls;

	always_comb begin
		known_op = (operation == OP_INIT) || (operation == OP_CMD) || (operation == OP_CHAR);
		cls.op = operation;
		cls.value = value;
		cls.clr = (operation == OP_CMD) && is_clear_cmd(value);
		full = (cnt_q == 2'd2);
		wr_en = push && !full && known_op;
		req_valid = (cnt_q != 2'd0);
		req_data = mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= !wptr_q;
			end
			if (req_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, req_pop};
		end
	end

	`CLCD_ASSERT(a_req_cnt_range, cnt_q <= 2'd2, "request queue count out of range")
	`CLCD_NEVER(a_req_pop_empty, req_pop && !req_valid, "request popped while empty")
	`CLCD_ASSERT(a_req_hold, (req_valid && !req_pop) |=> req_valid, "waiting request lost")

endmodule

`default_nettype wire

/* rtl/clcd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clcd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  clcd_pkg::cfg_idx_t  cfg_index,
	input  clcd_pkg::us_t       cfg_data,
	input  wire                 req_valid,
	input  clcd_pkg::req_t      req_data,
	output logic                req_pop,
	input  wire                 out_full,
	output logic                out_push,
	output clcd_pkg::phase_t    out_data
);
	import clcd_pkg::*;

	us_t             pulse_q;
	us_t             settle_q;
	us_t             power_wait_q;
	us_t             init_wait_q;
	us_t             clear_wait_q;

	logic            pwr_done_q;
	logic            low_q;
	logic [WR_W-1:0] wr_q;

	logic            in_init;
	logic            pwr_phase;
	logic            wr_past;
	logic [WR_W-1:0] tail_idx;
	byte_t           init_byte;
	byte_t           cur_byte;
	logic            cur_clr;
	us_t             extra;
	logic            run_end;

	always_comb begin
		in_init = (req_data.op == OP_INIT);
		pwr_phase = in_init && !pwr_done_q;
		wr_past = (wr_q >= WR_W'(FUNCTION_SET_REPEATS));
		tail_idx = wr_q - WR_W'(FUNCTION_SET_REPEATS);
		init_byte = wr_past ? init_tail_cmd(TAIL_IDX_W'(tail_idx)) : CMD_FUNC_SET_8;
		cur_byte = in_init ? init_byte : req_data.value;
		cur_clr = in_init ? (wr_past && is_clear_cmd(init_byte)) : req_data.clr;
		if (in_init && !wr_past) begin
			extra = init_wait_q;
		end else if (cur_clr) begin
			extra = clear_wait_q;
		end else begin
			extra = '0;
		end
		run_end = !in_init || (wr_q == WR_W'(INIT_WRITES - 1));

		out_push = req_valid && !out_full;
		out_data.register_select = (req_data.op == OP_CHAR);
		if (pwr_phase) begin
			out_data.lcd_data = 8'h00;
			out_data.register_select = 1'b0;
			out_data.enable = 1'b0;
			out_data.hold_us = {1'b0, power_wait_q};
			out_data.last = 1'b0;
		end else if (!low_q) begin
			out_data.lcd_data = cur_byte;
			out_data.enable = 1'b1;
			out_data.hold_us = {1'b0, pulse_q};
			out_data.last = 1'b0;
		end else begin
			out_data.lcd_data = cur_byte;
			out_data.enable = 1'b0;
			out_data.hold_us = {1'b0, settle_q} + {1'b0, extra};
			out_data.last = run_end;
		end
		req_pop = out_push && !pwr_phase && low_q && run_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= 16'd40;
			settle_q <= 16'd40;
			power_wait_q <= 16'd16000;
			init_wait_q <= 16'd5000;
			clear_wait_q <= 16'd16000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSE:      pulse_q <= cfg_data;
				REG_SETTLE:     settle_q <= cfg_data;
				REG_POWER_WAIT: power_wait_q <= cfg_data;
				REG_INIT_WAIT:  init_wait_q <= cfg_data;
				REG_CLEAR_WAIT: clear_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_done_q <= 1'b0;
			low_q <= 1'b0;
			wr_q <= '0;
		end else if (out_push) begin
			if (pwr_phase) begin
				pwr_done_q <= 1'b1;
			end else if (!low_q) begin
				low_q <= 1'b1;
			end else begin
				low_q <= 1'b0;
				if (run_end) begin
					wr_q <= '0;
					pwr_done_q <= 1'b0;
				end else begin
					wr_q <= wr_q + 1'b1;
				end
			end
		end
	end

	`CLCD_ASSERT(a_wr_range, wr_q <= WR_W'(INIT_WRITES - 1), "init write counter overrun")
	`CLCD_ASSERT(a_idle_clean, !req_valid |-> (!low_q && !pwr_done_q && wr_q == '0),
		"sequencer state left over without a request")
	`CLCD_ASSERT(a_pwr_only_init, pwr_done_q |-> (req_valid && in_init),
		"power-on phase marked outside an initialize run")

endmodule

`default_nettype wire

/* rtl/clcd_out_q.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clcd_out_q (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_push,
	output logic               in_full,
	input  clcd_pkg::phase_t   in_data,
	input  wire                pop,
	output logic               empty,
	output clcd_pkg::phase_t   head
);
	import clcd_pkg::*;

	phase_t     mem [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       rd_en;

	always_comb begin
		in_full = (cnt_q == 2'd2);
		empty = (cnt_q == 2'd0);
		rd_en = pop && !empty;
		head = mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (in_push) begin
			mem[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_push) begin
				wptr_q <= !wptr_q;
			end
			if (rd_en) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, in_push} - {1'b0, rd_en};
		end
	end

	`CLCD_NEVER(a_push_full, in_push && in_full, "phase pushed into a full result queue")
	`CLCD_ASSERT(a_out_cnt_range, cnt_q <= 2'd2, "result queue count out of range")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import clcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_CYCLES = 40;
	localparam int RANDOM_ITEMS = 15;
	localparam op_t OP_NONE = 2'd3;
	localparam cfg_idx_t REG_UNUSED_LO = 3'd5;
	localparam cfg_idx_t REG_UNUSED_MID = 3'd6;
	localparam cfg_idx_t REG_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	op_t operation;
	byte_t value;
	logic empty;
	logic pop;
	byte_t lcd_data;
	logic register_select;
	logic enable;
	hold_t hold_us;
	logic last;
	logic cfg_we;
	cfg_idx_t cfg_index;
	us_t cfg_data;

	// timing registers as the block should hold them
	us_t pulse_t;
	us_t settle_t;
	us_t power_wait_t;
	us_t init_wait_t;
	us_t clear_wait_t;

	phase_t pending_phases[$];
	phase_t staged;
	bit staged_v;

	bit src_idle_en;
	bit sink_idle_en;
	int sink_hold_len;
	int sink_hold_req;
	int sink_hold_ack;
	int sink_hold_left;

	int cycle_count;
	int fail_count;
	int requests_taken;
	int inits_taken;
	int dropped_taken;
	int phases_checked;
	int full_stalls;

	char_lcd_write_sequencer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.value(value),
		.empty(empty),
		.pop(pop),
		.lcd_data(lcd_data),
		.register_select(register_select),
		.enable(enable),
		.hold_us(hold_us),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// phase expansion of one request
	task automatic add_phase(input byte_t d, input logic rs, input logic en, input hold_t h);
		if (staged_v)
			pending_phases.push_back(staged);
		staged.lcd_data = d;
		staged.register_select = rs;
		staged.enable = en;
		staged.hold_us = h;
		staged.last = 1'b0;
		staged_v = 1'b1;
	endtask

	task automatic add_write(input byte_t d, input logic rs, input us_t extra);
		add_phase(d, rs, 1'b1, hold_t'(pulse_t));
		add_phase(d, rs, 1'b0, hold_t'(settle_t) + hold_t'(extra));
	endtask

	task automatic add_cmd(input byte_t c);
		add_write(c, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ? clear_wait_t : 16'd0);
	endtask

	task automatic expand_request(input op_t op, input byte_t val);
		int i;
		staged_v = 1'b0;
		case (op)
			OP_INIT: begin
				add_phase(8'h00, 1'b0, 1'b0, hold_t'(power_wait_t));
				for (i = 0; i < FUNCTION_SET_REPEATS; i++)
					add_write(CMD_FUNC_SET_8, 1'b0, init_wait_t);
				add_cmd(CMD_FUNC_SET_2L);
				add_cmd(CMD_DISPLAY_ON);
				add_cmd(CMD_ENTRY_MODE);
				add_cmd(CMD_CLEAR);
				add_cmd(CMD_HOME);
			end
			OP_CMD: add_cmd(val);
			OP_CHAR: add_write(val, 1'b1, 16'd0);
			default: ;
		endcase
		if (staged_v) begin
			staged.last = 1'b1;
			pending_phases.push_back(staged);
		end
	endtask

	// prediction on push, comparison on pop, in one process
	always @(posedge clk) begin
		phase_t want;
		if (arst_n && push && full)
			full_stalls++;
		if (arst_n && push && !full) begin
			expand_request(operation, value);
			requests_taken++;
			if (operation == OP_INIT)
				inits_taken++;
			if (operation == OP_NONE)
				dropped_taken++;
		end
		if (arst_n && pop && !empty) begin
			if (pending_phases.size() == 0) begin
				$error("phase with nothing pending: lcd_data %h hold_us %0d", lcd_data, hold_us);
				fail_count++;
			end else begin
				want = pending_phases.pop_front();
				phases_checked++;
				if (lcd_data !== want.lcd_data) begin
					$error("lcd_data expected %h actual %h", want.lcd_data, lcd_data);
					fail_count++;
				end
				if (register_select !== want.register_select) begin
					$error("register_select expected %b actual %b", want.register_select,
						register_select);
					fail_count++;
				end
				if (enable !== want.enable) begin
					$error("enable expected %b actual %b", want.enable, enable);
					fail_count++;
				end
				if (hold_us !== want.hold_us) begin
					$error("hold_us expected %0d actual %0d", want.hold_us, hold_us);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last expected %b actual %b", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, or a counted hold-off on request
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req != sink_hold_ack) begin
				sink_hold_ack = sink_hold_req;
				sink_hold_left = sink_hold_len;
			end
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				pop <= 1'b0;
			end else if (sink_idle_en) begin
				pop <= ($urandom_range(99) >= 33);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d phases pending", cycle_count,
				pending_phases.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input op_t op, input byte_t val);
		while (src_idle_en && $urandom_range(99) < 33) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		value <= val;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		// let the last accepted item reach the prediction first
		@(posedge clk);
		while (pending_phases.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input us_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_PULSE: pulse_t = data;
			REG_SETTLE: settle_t = data;
			REG_POWER_WAIT: power_wait_t = data;
			REG_INIT_WAIT: init_wait_t = data;
			REG_CLEAR_WAIT: clear_wait_t = data;
			default: ;
		endcase
	endtask

	task automatic set_timing(input us_t p, input us_t s, input us_t pw, input us_t iw,
			input us_t cw);
		write_reg(REG_PULSE, p);
		write_reg(REG_SETTLE, s);
		write_reg(REG_POWER_WAIT, pw);
		write_reg(REG_INIT_WAIT, iw);
		write_reg(REG_CLEAR_WAIT, cw);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic us_t pick_us();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 16'd0;
		if (r < 30)
			return 16'hFFFF;
		if (r < 60)
			return us_t'($urandom_range(1, 200));
		return us_t'($urandom_range(65535));
	endfunction

	function automatic byte_t pick_cmd();
		case ($urandom_range(5))
			0: return CMD_CLEAR;
			1: return CMD_HOME;
			2: return CMD_FUNC_SET_8;
			default: return byte_t'($urandom_range(255));
		endcase
	endfunction

	task automatic test_reset_timing();
		send_item(OP_INIT, 8'hFF);
		send_item(OP_CMD, 8'h00);
		send_item(OP_CMD, CMD_CLEAR);
		send_item(OP_CMD, CMD_HOME);
		send_item(OP_CMD, 8'h03);
		send_item(OP_CMD, 8'hFF);
		send_item(OP_CMD, CMD_FUNC_SET_8);
		send_item(OP_CHAR, 8'h00);
		send_item(OP_CHAR, 8'hFF);
		send_item(OP_CHAR, CMD_CLEAR);
		send_item(OP_CHAR, CMD_HOME);
		send_item(OP_NONE, 8'h00);
		send_item(OP_NONE, 8'hFF);
		wait_drained();
	endtask

	task automatic test_timing_extremes();
		// largest holds: settle plus extra wait needs all 17 bits
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_INIT, 8'h00);
		send_item(OP_CMD, CMD_CLEAR);
		send_item(OP_CMD, CMD_HOME);
		send_item(OP_CHAR, 8'hAA);
		send_item(OP_CMD, 8'h55);
		wait_drained();
		// zero holds, pulse and settle included
		set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_item(OP_INIT, 8'h5A);
		send_item(OP_CMD, CMD_HOME);
		send_item(OP_CHAR, 8'h55);
		wait_drained();
		set_timing(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
		// writes beyond the register list must change nothing
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_MID, 16'hA5A5);
		write_reg(REG_UNUSED_HI, 16'h5A5A);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_item(OP_INIT, 8'h00);
		send_item(OP_CMD, CMD_CLEAR);
		send_item(OP_CHAR, 8'hFF);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		set_timing(16'd40, 16'd40, 16'd16000, 16'd5000, 16'd16000);
		src_idle_en = 1'b0;
		sink_hold_len = 300;
		sink_hold_req++;
		send_item(OP_INIT, 8'h00);
		for (i = 0; i < 10; i++)
			send_item($urandom_range(1) ? OP_CMD : OP_CHAR, byte_t'($urandom_range(255)));
		// sender waits for the queue to empty, then resumes
		wait_drained();
		src_idle_en = 1'b1;
		for (i = 0; i < 6; i++)
			send_item(OP_CMD, pick_cmd());
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int phase;
		int counted;
		int r;
		for (phase = 0; phase < 4; phase++) begin
			set_timing(pick_us(), pick_us(), pick_us(), pick_us(), pick_us());
			// one stretch with no idling on either side
			src_idle_en = (phase != 2);
			sink_idle_en = (phase != 2);
			counted = 0;
			while (counted < RANDOM_ITEMS) begin
				r = $urandom_range(99);
				if (r < 6) begin
					send_item(OP_INIT, byte_t'($urandom_range(255)));
					counted++;
				end else if (r < 11) begin
					send_item(OP_NONE, byte_t'($urandom_range(255)));
				end else if (r < 55) begin
					send_item(OP_CMD, pick_cmd());
					counted++;
				end else begin
					send_item(OP_CHAR, byte_t'($urandom_range(255)));
					counted++;
				end
			end
			wait_drained();
		end
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		operation = OP_INIT;
		value = 8'h00;
		cfg_we = 1'b0;
		cfg_index = REG_PULSE;
		cfg_data = 16'd0;
		pulse_t = 16'd40;
		settle_t = 16'd40;
		power_wait_t = 16'd16000;
		init_wait_t = 16'd5000;
		clear_wait_t = 16'd16000;
		staged_v = 1'b0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		sink_hold_len = 0;
		sink_hold_req = 0;
		sink_hold_ack = 0;
		sink_hold_left = 0;
		cycle_count = 0;
		fail_count = 0;
		requests_taken = 0;
		inits_taken = 0;
		dropped_taken = 0;
		phases_checked = 0;
		full_stalls = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_timing_extremes();
		test_backpressure();
		test_random_traffic();
		wait_drained();

		$display("%0d requests taken (%0d initialize, %0d unused code), %0d phases checked",
			requests_taken, inits_taken, dropped_taken, phases_checked);
		$display("timing set to reset, extreme and random values; %0d cycles with input held off",
			full_stalls);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
